// ===== rtl/gsqp_pkg.sv =====
// Package for the Gold sequence QPSK pilot generator.
// Holds the LFSR step functions, the build-time jump-ahead and amplitude functions,
// and the result struct. No dependencies.
package gsqp_pkg;

    localparam int LFSR_W           = 31;
    localparam int MSB_POS          = 30;
    localparam int VAL_W            = 16;
    localparam int WARMUP_STEPS_DEF = 1600;
    localparam int FRAC_BITS_DEF    = 15;
    localparam logic [VAL_W-1:0] AMP_MAX = 16'd32767;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_PILOT = 1'b1;

    typedef logic [LFSR_W-1:0]              t_lfsr;
    typedef logic [LFSR_W-1:0][LFSR_W-1:0]  t_jump;
    typedef logic signed [VAL_W-1:0]        t_value;

    typedef struct packed {
        logic   is_pilot;
        t_value re_value;
        t_value im_value;
        logic   bit_even;
        logic   bit_odd;
        logic   last;
    } t_result;

    // x1(n+31) = x1(n+3) ^ x1(n)
    function automatic t_lfsr step_one(input t_lfsr x);
        return {x[3] ^ x[0], x[MSB_POS:1]};
    endfunction

    // x2(n+31) = x2(n+3) ^ x2(n+2) ^ x2(n+1) ^ x2(n)
    function automatic t_lfsr step_two(input t_lfsr x);
        return {x[3] ^ x[2] ^ x[1] ^ x[0], x[MSB_POS:1]};
    endfunction

    // x1 after warm-up from the fixed start value 1
    function automatic t_lfsr warm_one(input int steps);
        t_lfsr v;
        v = t_lfsr'(1);
        for (int k = 0; k < steps; k++) begin
            v = step_one(v);
        end
        return v;
    endfunction

    // Column j: image of unit vector j after the warm-up steps of x2
    function automatic t_jump jump_two(input int steps);
        t_jump m;
        t_lfsr v;
        for (int j = 0; j < LFSR_W; j++) begin
            v = t_lfsr'(1) << j;
            for (int k = 0; k < steps; k++) begin
                v = step_two(v);
            end
            m[j] = v;
        end
        return m;
    endfunction

    // round(2^f / sqrt2), saturated
    function automatic logic [VAL_W-1:0] pilot_amp(input int f);
        longint unsigned target;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned odd;
        if (f == 0) begin
            return 16'd1;
        end
        if (f > 31) begin
            return AMP_MAX;
        end
        target = 64'd1 << (2 * f - 1);
        lo     = 64'd0;
        hi     = 64'd1 << 31;
        while (hi - lo > 64'd1) begin
            mid = lo + (hi - lo) / 2;
            if (mid * mid <= target) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        odd = 2 * lo + 1;
        if (odd * odd < 4 * target) begin
            lo = lo + 1;
        end
        if (lo > 64'(AMP_MAX)) begin
            lo = 64'(AMP_MAX);
        end
        return lo[VAL_W-1:0];
    endfunction

endpackage

// ===== rtl/gsqp_step.sv =====
// Next-state and result logic for one request of the pilot generator.
// Start: jump-ahead load of both LFSRs; pilot: two bits, two steps, QPSK map.
// Depends on gsqp_pkg.
module gsqp_step #(
    parameter int WARMUP_STEPS = gsqp_pkg::WARMUP_STEPS_DEF,
    parameter int FRAC_BITS    = gsqp_pkg::FRAC_BITS_DEF
) (
    input  gsqp_pkg::t_lfsr   i_x1,
    input  gsqp_pkg::t_lfsr   i_x2,
    input  logic              i_req_type,
    input  gsqp_pkg::t_lfsr   i_seed,
    input  logic              i_final_pilot,
    output gsqp_pkg::t_lfsr   o_x1,
    output gsqp_pkg::t_lfsr   o_x2,
    output gsqp_pkg::t_result o_result
);
    import gsqp_pkg::*;

    localparam t_lfsr  X1_WARM = warm_one(WARMUP_STEPS);
    localparam t_jump  X2_JUMP = jump_two(WARMUP_STEPS);
    localparam t_value AMP     = t_value'(pilot_amp(FRAC_BITS));
    localparam t_value AMP_NEG = -AMP;

    t_lfsr x2_warm;
    logic  bit_even;
    logic  bit_odd;

    always_comb begin
        x2_warm = '0;
        for (int j = 0; j < LFSR_W; j++) begin
            if (i_seed[j]) begin
                x2_warm = x2_warm ^ X2_JUMP[j];
            end
        end
    end

    assign bit_even = i_x1[0] ^ i_x2[0];
    assign bit_odd  = i_x1[1] ^ i_x2[1];

    always_comb begin
        unique case (i_req_type)
            REQ_START: begin
                o_x1     = X1_WARM;
                o_x2     = x2_warm;
                o_result = '0;
            end
            REQ_PILOT: begin
                o_x1              = step_one(step_one(i_x1));
                o_x2              = step_two(step_two(i_x2));
                o_result.is_pilot = 1'b1;
                o_result.re_value = bit_even ? AMP_NEG : AMP;
                o_result.im_value = bit_odd ? AMP_NEG : AMP;
                o_result.bit_even = bit_even;
                o_result.bit_odd  = bit_odd;
                o_result.last     = i_final_pilot;
            end
            default: begin
                o_x1     = i_x1;
                o_x2     = i_x2;
                o_result = '0;
            end
        endcase
    end

endmodule

// ===== rtl/gold_sequence_qpsk_pilot_generator.sv =====
// Top level of the Gold sequence QPSK pilot generator: state and result registers.
// Depends on gsqp_pkg and gsqp_step.
//
// One request per clock while the output is not stalled, one registered result per request. A start request
// (req_type 0) loads x2 from the seed and x1 from 1, both advanced by WARMUP_STEPS with a
// jump-ahead matrix built at elaboration, and returns an all-zero acknowledgement. A pilot
// request (req_type 1) returns c(2n), c(2n+1) and their QPSK values +/-round(2^FRAC_BITS/sqrt2)
// and advances the generator by two steps. The single result register is refilled in the
// same cycle it is taken, so the input stalls only while the output is stalled.
module gold_sequence_qpsk_pilot_generator #(
    parameter int WARMUP_STEPS = gsqp_pkg::WARMUP_STEPS_DEF,
    parameter int FRAC_BITS    = gsqp_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_req_type,
    input  logic [30:0]           i_seed,
    input  logic                  i_final_pilot,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_is_pilot,
    output logic signed [15:0]    o_re_value,
    output logic signed [15:0]    o_im_value,
    output logic                  o_bit_even,
    output logic                  o_bit_odd,
    output logic                  o_last
);
    import gsqp_pkg::*;

    localparam t_lfsr X1_RESET = warm_one(WARMUP_STEPS);

    t_lfsr   r_x1;
    t_lfsr   r_x2;
    t_lfsr   n_x1;
    t_lfsr   n_x2;
    logic    r_valid;
    t_result r_result;
    t_result n_result;
    logic    accept;

    assign o_stall = r_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    gsqp_step #(
        .WARMUP_STEPS (WARMUP_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_step (
        .i_x1          (r_x1),
        .i_x2          (r_x2),
        .i_req_type    (i_req_type),
        .i_seed        (i_seed),
        .i_final_pilot (i_final_pilot),
        .o_x1          (n_x1),
        .o_x2          (n_x2),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1    <= X1_RESET;
            r_x2    <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_x1 <= n_x1;
                r_x2 <= n_x2;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid    = r_valid;
    assign o_is_pilot = r_result.is_pilot;
    assign o_re_value = r_result.re_value;
    assign o_im_value = r_result.im_value;
    assign o_bit_even = r_result.bit_even;
    assign o_bit_odd  = r_result.bit_odd;
    assign o_last     = r_result.last;

endmodule
